### hw/rtl/acs_pkg.sv
// Package for the adaptive cross sharpener: field widths, register indexes,
// reset values and the sequencer state type. No dependencies.
`default_nettype none

package acs_pkg;

  // Payload and register widths
  localparam int PIX_W   = 8;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 11;
  localparam int CFG_W   = 12;
  localparam int STR_W   = 8;
  localparam int CIDX_W  = 2;

  // Default line store depth
  localparam int MAX_WIDTH_DEF = 2048;

  // Register reset values
  localparam logic [CFG_W-1:0] WIDTH_RST    = 12'd2048;
  localparam logic [CFG_W-1:0] HEIGHT_RST   = 12'd1080;
  localparam logic [STR_W-1:0] STRENGTH_RST = 8'd0;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_STRENGTH     = 2'd2;

  // Per-pixel sequencer
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_GAIN = 5'b00100,
    S_PROD = 5'b01000,
    S_FIN  = 5'b10000
  } acs_state_e;

endpackage

`default_nettype wire

### hw/rtl/adaptive_cross_sharpen.sv
// Adaptive cross sharpener top level: two line stores, per-pixel sequencer
// and output register. Depends on acs_pkg.
//
// Takes one 8-bit luma pixel per word in raster order and emits the pixel of
// the line above once its four-neighbour cross is complete; on the last line
// of a frame the arriving pixel follows as a second word. Results are loaded
// through these steps after a pixel is accepted: the synchronous line store read at
// acceptance, then min/max/mean, the gain multiply and the correction
// multiply, each registered, and the clamp into the output register. The
// sequencer returns to idle with the load and takes no new pixel until it is
// back in idle. The load waits while the previous results are still held in
// the two-word output register, so a stalled output slows the input side.
// There is no clearing pass: line store entries are valid once written by a
// preceding line.
`default_nettype none

module adaptive_cross_sharpen #(
  parameter int MAX_WIDTH = acs_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Input pixel channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [acs_pkg::PIX_W-1:0]  pixel_in_i,
  // Result channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [acs_pkg::PIX_W-1:0]       pixel_out_o,
  output logic [acs_pkg::ROW_W-1:0]       out_row_o,
  output logic [acs_pkg::COL_W-1:0]       out_col_o,
  output logic                            run_last_o,
  // Configuration write port
  input  wire logic                       cfg_we_i,
  input  wire logic [acs_pkg::CIDX_W-1:0] cfg_index_i,
  input  wire logic [acs_pkg::CFG_W-1:0]  cfg_data_i
);
  import acs_pkg::*;

  // Address and comparison widths follow the line store depth
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int XW  = ((WCW > CFG_W) ? WCW : CFG_W) + 1;
  localparam int RXW = ROW_W + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [CFG_W-1:0] width_q, height_q;
  logic [STR_W-1:0] strength_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      strength_q <= STRENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q    <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q   <= cfg_data_i;
        CFG_STRENGTH:     strength_q <= cfg_data_i[STR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state and handshake
  acs_state_e state_q, state_d;
  logic       in_acc;
  logic       load_out;
  logic       any_res_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // Position: effective frame size and wrap of stale counters
  logic [AW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic [XW-1:0]    w_x, w_eff, col_x, c_x, c_nx;
  logic [RXW-1:0]   h_eff, row_x, r_x, r_nx;
  logic             wrap_col;

  always_comb begin
    w_x = XW'(width_q);
    if (w_x == '0) begin
      w_eff = XW'(1);
    end else if (w_x > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = w_x;
    end
    h_eff = (height_q == '0) ? RXW'(1) : RXW'(height_q);

    col_x    = XW'(col_q);
    wrap_col = (col_x >= w_eff);
    c_x      = wrap_col ? '0 : col_x;
    row_x    = RXW'(row_q) + (wrap_col ? RXW'(1) : '0);
    r_x      = (row_x >= h_eff) ? '0 : row_x;

    // counters after this pixel
    c_nx = c_x + XW'(1);
    r_nx = r_x;
    if (c_nx == w_eff) begin
      c_nx = '0;
      r_nx = r_x + RXW'(1);
      if (r_nx == h_eff) begin
        r_nx = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= c_nx[AW-1:0];
      row_q <= r_nx[ROW_W-1:0];
    end
  end

  // Per-pixel flags captured at acceptance
  logic [PIX_W-1:0] pix_q;
  logic [AW-1:0]    c_q;
  logic [ROW_W-1:0] r_q;
  logic             right_ok_q, one_line_q, two_res_q, interior_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q      <= pixel_in_i;
      c_q        <= c_x[AW-1:0];
      r_q        <= r_x[ROW_W-1:0];
      right_ok_q <= ((c_x + XW'(1)) < w_eff);
      one_line_q <= (h_eff == RXW'(1));
      two_res_q  <= (h_eff != RXW'(1)) && (r_x != '0) && (r_x == h_eff - RXW'(1));
      any_res_q  <= (h_eff == RXW'(1)) || (r_x != '0);
      interior_q <= (r_x >= RXW'(2)) && (c_x != '0) && ((c_x + XW'(1)) < w_eff);
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: read centre, right and above at acceptance, write back
  // the centre and the new pixel once the read data is in
  logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] prev_c_q, prev_r_q, older_c_q;
  logic [AW-1:0]    addr_r;
  logic             mem_wr;

  assign addr_r = c_x[AW-1:0] + AW'(1);
  assign mem_wr = (state_q == S_READ);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_c_q  <= prev_mem[c_x[AW-1:0]];
      prev_r_q  <= prev_mem[addr_r];
      older_c_q <= older_mem[c_x[AW-1:0]];
    end
    if (mem_wr) begin
      prev_mem[c_q]  <= pix_q;
      older_mem[c_q] <= prev_c_q;
    end
  end

  // Left neighbour: centre of the previous pixel
  logic [PIX_W-1:0] left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (mem_wr) begin
      left_q <= prev_c_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: cross min, max, rounded mean
  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] x,
                                             input logic [PIX_W-1:0] y);
    min2 = (x < y) ? x : y;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] x,
                                             input logic [PIX_W-1:0] y);
    max2 = (x > y) ? x : y;
  endfunction

  logic [PIX_W-1:0] s_a, s_b, s_d, s_e, s_h, s_mn, s_mx;
  logic [PIX_W+1:0] s_sum;

  always_comb begin
    s_a   = prev_c_q;
    s_b   = older_c_q;
    s_d   = left_q;
    s_e   = right_ok_q ? prev_r_q : '0;
    s_h   = pix_q;
    s_mn  = min2(min2(min2(s_a, s_b), min2(s_d, s_e)), s_h);
    s_mx  = max2(max2(max2(s_a, s_b), max2(s_d, s_e)), s_h);
    s_sum = (PIX_W+2)'(s_b) + (PIX_W+2)'(s_d) + (PIX_W+2)'(s_e)
          + (PIX_W+2)'(s_h) + (PIX_W+2)'(2);
  end

  logic [PIX_W-1:0] a_q, mn_q, mx_q, mean_q, rng_q;

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      a_q    <= s_a;
      mn_q   <= s_mn;
      mx_q   <= s_mx;
      mean_q <= s_sum[PIX_W+1:2];
      rng_q  <= s_mx - s_mn;
    end
  end

  // Stage 2: gain = strength * range >> 9, and centre minus mean
  logic [STR_W+PIX_W-1:0] gprod;
  logic [6:0]             gain_q;
  logic signed [PIX_W:0]  diff_q;

  assign gprod = (STR_W+PIX_W)'(strength_q) * (STR_W+PIX_W)'(rng_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_GAIN) begin
      gain_q <= gprod[STR_W+PIX_W-1:9];
      diff_q <= $signed({1'b0, a_q}) - $signed({1'b0, mean_q});
    end
  end

  // Stage 3: correction product
  logic signed [16:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_PROD) begin
      prod_q <= diff_q * $signed({1'b0, gain_q});
    end
  end

  // Stage 4: floor divide by 256, add, clamp to the cross range
  logic signed [PIX_W:0]   adj;
  logic signed [PIX_W+2:0] sum_s;
  logic [PIX_W-1:0]        clamped, sharp_val;

  always_comb begin
    adj   = (PIX_W+1)'(prod_q >>> 8);
    sum_s = $signed({3'b000, a_q}) + (PIX_W+3)'(adj);
    if (sum_s < $signed({3'b000, mn_q})) begin
      clamped = mn_q;
    end else if (sum_s > $signed({3'b000, mx_q})) begin
      clamped = mx_q;
    end else begin
      clamped = sum_s[PIX_W-1:0];
    end
    sharp_val = (interior_q && (gain_q != '0)) ? clamped : a_q;
  end

  // ---------------------------------------------------------------------
  // Sequencer
  logic out_valid_q, sec_valid_q;

  assign load_out = (state_q == S_FIN) && any_res_q && !out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_READ;
      S_READ: state_d = S_GAIN;
      S_GAIN: state_d = S_PROD;
      S_PROD: state_d = S_FIN;
      S_FIN: begin
        if (!any_res_q || !out_valid_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // Two-word output register: first word shown, second queued behind it
  logic [PIX_W-1:0] out_pix_q, sec_pix_q;
  logic [ROW_W-1:0] out_row_q, sec_row_q;
  logic [AW-1:0]    out_col_q, sec_col_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
      sec_valid_q <= two_res_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= sec_valid_q;
      sec_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (one_line_q) begin
        out_pix_q <= pix_q;
        out_row_q <= r_q;
      end else begin
        out_pix_q <= sharp_val;
        out_row_q <= r_q - ROW_W'(1);
      end
      out_col_q  <= c_q;
      out_last_q <= !two_res_q;
      sec_pix_q  <= pix_q;
      sec_row_q  <= r_q;
      sec_col_q  <= c_q;
    end else if (out_valid_q && !out_stall_i && sec_valid_q) begin
      out_pix_q  <= sec_pix_q;
      out_row_q  <= sec_row_q;
      out_col_q  <= sec_col_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = COL_W'(out_col_q);
  assign run_last_o  = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions

  // a queued second word always sits behind a shown first word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_valid_q |-> out_valid_q)
    else $error("second result queued without a first");

  // a word that is not the last of its pixel has its follower queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_last_o) |-> sec_valid_q)
    else $error("non-last result without a follower");

  // one pixel at a time: busy in the cycle after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a pixel is in flight");

  // results are loaded only into an empty output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q && !sec_valid_q))
    else $error("output register overwritten");

endmodule

`default_nettype wire
